// ===== src/sfr_pkg.sv =====
// shared constants and types of the serial frame receiver
package sfr_pkg;

  // frame format
  localparam int PAYLOAD_LEN  = 7;
  localparam int STORE_DEPTH  = 7;
  localparam int STORE_IDX_W  = $clog2(STORE_DEPTH);
  localparam int COUNT_W      = 7;
  localparam logic [7:0] HDR_BYTE  = 8'hA5;
  localparam logic [7:0] TAIL_BYTE = 8'h5A;
  localparam logic [7:0] SUM_INIT  = 8'h00;

  // queue between parser and output stage
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // output word width: mode plus three 16-bit channels
  localparam int OUT_W = 56;

  // the stored payload bytes of one frame, byte 0 in the low bits
  typedef logic [STORE_DEPTH-1:0][7:0] frame_t;

  // a completed frame handed from the parser to the queue
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } push_t;

  // queue status seen by both sides
  typedef struct packed {
    logic ready;
    logic valid;
  } q_stat_t;

endpackage

// ===== src/serial_frame_receiver_top.sv =====
// top level of the serial frame receiver
//
// Input stream s_*: one received byte per transaction in s_tdata. The
// parser hunts for header 0xA5, takes the payload bytes while summing
// them, then checks the sum byte and the tail 0x5A. A bad sum or tail
// drops the frame silently and hunting resumes with the next byte.
// Output stream m_*: one transaction per good frame, m_tdata holds mode
// in [7:0] and the signed channels x, y, turn in [23:8], [39:24], [55:40].
// Throughput is one byte per cycle while s_tready is high. A frame reaches
// m_* through the queue and the output register: the edge that takes its
// tail byte writes the frame into the queue, and a later edge, once the
// output register is free, loads it. A two-entry frame queue parts the
// parser from the output register, so bytes keep flowing while a result
// waits. s_tready drops only when the queue is full, i.e. the sink has
// stalled across several frames. Reset (rst, synchronous) returns the
// parser to hunting and empties the queue and the output register.
module serial_frame_receiver_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // rx_byte
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [sfr_pkg::OUT_W-1:0] m_tdata    // mode, channel_x, channel_y, channel_turn
);
  import sfr_pkg::*;

  push_t   push;
  q_stat_t stat;
  frame_t  head;
  logic    pop;

  assign s_tready = stat.ready;

  sfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .push     (push)
  );

  sfr_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .stat (stat),
    .head (head)
  );

  sfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // a frame is never pushed into a full queue
  assert property (@(posedge clk) disable iff (rst) !(push.valid && !stat.ready))
    else $error("frame pushed into full queue");

  // a frame is only pushed on an accepted byte
  assert property (@(posedge clk) disable iff (rst) push.valid |-> (s_tvalid && s_tready))
    else $error("frame push without accepted byte");

  // the output stage only loads when the queue has a frame
  assert property (@(posedge clk) disable iff (rst) pop |-> stat.valid)
    else $error("pop from empty queue");

  // nothing is offered right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

// ===== src/sfr_front.sv =====
// byte parser: hunts for the header, collects payload, checks sum and tail
module sfr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tready,
  input  logic [7:0]    s_tdata,   // rx_byte
  output sfr_pkg::push_t push
);
  import sfr_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_SUM  = 2'd2,
    PH_TAIL = 2'd3
  } phase_t;

  phase_t             phase;
  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         running_sum;
  frame_t             store;

  logic               accept;
  logic [COUNT_W-1:0] count_inc;

  assign accept    = s_tvalid && s_tready;
  assign count_inc = byte_count + COUNT_W'(1);

  // frame state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_count  <= '0;
      running_sum <= SUM_INIT;
    end else if (accept) begin
      case (phase)
        PH_HUNT: begin
          if (s_tdata == HDR_BYTE) begin
            phase       <= PH_DATA;
            byte_count  <= '0;
            running_sum <= SUM_INIT;
          end
        end
        PH_DATA: begin
          running_sum <= running_sum + s_tdata;
          byte_count  <= count_inc;
          if (count_inc >= COUNT_W'(PAYLOAD_LEN)) begin
            phase <= PH_SUM;
          end
        end
        PH_SUM: begin
          phase <= (s_tdata == running_sum) ? PH_TAIL : PH_HUNT;
        end
        PH_TAIL: begin
          phase <= PH_HUNT;
        end
        default: begin
          phase <= PH_HUNT;
        end
      endcase
    end
  end

  // payload capture, bytes past the store only feed the sum
  always_ff @(posedge clk) begin
    if (accept && phase == PH_DATA && byte_count < COUNT_W'(STORE_DEPTH)) begin
      store[byte_count[STORE_IDX_W-1:0]] <= s_tdata;
    end
  end

  // good tail closes the frame
  assign push.valid = accept && phase == PH_TAIL && s_tdata == TAIL_BYTE;
  assign push.frame = store;

endmodule

// ===== src/sfr_queue.sv =====
// short queue of completed frames between parser and output stage
module sfr_queue (
  input  logic              clk,
  input  logic              rst,
  input  sfr_pkg::push_t    push,
  input  logic              pop,
  output sfr_pkg::q_stat_t  stat,
  output sfr_pkg::frame_t   head
);
  import sfr_pkg::*;

  frame_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign stat.ready = count != QCNT_W'(QUEUE_DEPTH);
  assign stat.valid = count != '0;
  assign do_push    = push.valid && stat.ready;
  assign do_pop     = pop && stat.valid;
  assign head       = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.frame;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== src/sfr_back.sv =====
// output stage: unpacks a frame into mode and channels and holds it for the sink
module sfr_back (
  input  logic                      clk,
  input  logic                      rst,
  input  sfr_pkg::q_stat_t          stat,
  input  sfr_pkg::frame_t           head,
  output logic                      pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [sfr_pkg::OUT_W-1:0] m_tdata   // mode, channel_x, channel_y, channel_turn
);
  import sfr_pkg::*;

  logic              out_valid;
  logic [7:0]        mode;
  logic signed [15:0] channel_x;
  logic signed [15:0] channel_y;
  logic signed [15:0] channel_turn;

  assign pop = stat.valid && (!out_valid || m_tready);

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // little-endian channel assembly
  always_ff @(posedge clk) begin
    if (pop) begin
      mode         <= head[0];
      channel_x    <= signed'({head[2], head[1]});
      channel_y    <= signed'({head[4], head[3]});
      channel_turn <= signed'({head[6], head[5]});
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {channel_turn, channel_y, channel_x, mode};

endmodule
